@@ sv/spvt_pkg.sv @@
// Package for the seed position vote table.
// Holds the beat types, field widths and operation codes; no dependencies.
`default_nettype none

package spvt_pkg;

  localparam int POS_W    = 32;
  localparam int OFFSET_W = 9;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] VOTE_MAX        = '1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd4;

  typedef enum logic {
    OP_VOTE   = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [POS_W-1:0]    hit_pos;
    logic [OFFSET_W-1:0] seed_offset;
    logic                variant_mode;
  } vote_in_t;

  typedef struct packed {
    logic               inserted;
    logic [POS_W-1:0]   best_pos;
    logic [COUNT_W-1:0] best_count;
    logic               best_found;
    logic [POS_W-1:0]   second_pos;
    logic [COUNT_W-1:0] second_count;
    logic               second_found;
  } result_t;

endpackage

`default_nettype wire

@@ sv/spvt_table.sv @@
// Basket storage of the seed position vote table: start and count registers,
// adjusted start computation, first-fit basket pick and clear on finish.
// Depends on spvt_pkg.
`default_nettype none

module spvt_table #(
  parameter int NUM_BASKETS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire spvt_pkg::vote_in_t item,
  output logic [31:0]            basket_start [NUM_BASKETS],
  output logic [15:0]            basket_votes [NUM_BASKETS],
  output logic                   inserted
);
  import spvt_pkg::*;

  logic [POS_W:0]          diff;
  logic                    negative;
  logic [POS_W-1:0]        adj_start;
  logic                    vote_ok;
  logic [NUM_BASKETS-1:0]  hit;
  logic [NUM_BASKETS-1:0]  pick;

  always_comb begin
    diff      = {1'b0, item.hit_pos} - {{(POS_W+1-OFFSET_W){1'b0}}, item.seed_offset};
    negative  = diff[POS_W];
    adj_start = negative ? '0 : diff[POS_W-1:0];
    if (item.variant_mode) begin
      vote_ok = !negative && (diff[POS_W-1:0] != '0);
    end else begin
      vote_ok = 1'b1;
    end
    for (int b = 0; b < NUM_BASKETS; b++) begin
      hit[b] = (basket_start[b] == '0) || (basket_start[b] == adj_start);
    end
    pick     = hit & (~hit + NUM_BASKETS'(1));
    inserted = vote_ok && (hit != '0) && (item.operation == OP_VOTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BASKETS; b++) begin
        basket_start[b] <= '0;
        basket_votes[b] <= '0;
      end
    end else if (take) begin
      if (item.operation == OP_FINISH) begin
        for (int b = 0; b < NUM_BASKETS; b++) begin
          basket_start[b] <= '0;
          basket_votes[b] <= '0;
        end
      end else if (vote_ok) begin
        for (int b = 0; b < NUM_BASKETS; b++) begin
          if (pick[b]) begin
            basket_start[b] <= adj_start;
            if (basket_votes[b] != VOTE_MAX) begin
              basket_votes[b] <= basket_votes[b] + COUNT_W'(1);
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/spvt_rank.sv @@
// Winner selection of the seed position vote table: pairwise count compares
// pick the best and second basket in the order of a forward scan.
// Depends on spvt_pkg.
`default_nettype none

module spvt_rank #(
  parameter int NUM_BASKETS = 10
) (
  input  wire logic [31:0]       basket_start [NUM_BASKETS],
  input  wire logic [15:0]       basket_votes [NUM_BASKETS],
  input  wire logic [15:0]       hit_threshold,
  output spvt_pkg::result_t      report
);
  import spvt_pkg::*;

  logic [NUM_BASKETS-1:0] gt [NUM_BASKETS];
  logic [NUM_BASKETS-1:0] qual;
  logic [NUM_BASKETS-1:0] best_sel;
  logic [NUM_BASKETS-1:0] second_sel;
  logic                   blocked;
  logic [POS_W-1:0]       best_p;
  logic [POS_W-1:0]       second_p;
  logic [COUNT_W-1:0]     best_c;
  logic [COUNT_W-1:0]     second_c;

  // A basket can become second only when an earlier basket has a larger count.
  always_comb begin
    for (int b = 0; b < NUM_BASKETS; b++) begin
      for (int j = 0; j < NUM_BASKETS; j++) begin
        gt[b][j] = basket_votes[j] > basket_votes[b];
      end
    end
    for (int b = 0; b < NUM_BASKETS; b++) begin
      qual[b] = 1'b0;
      for (int j = 0; j < b; j++) begin
        qual[b] = qual[b] | gt[b][j];
      end
    end
    for (int b = 0; b < NUM_BASKETS; b++) begin
      blocked = 1'b0;
      for (int j = 0; j < NUM_BASKETS; j++) begin
        if (j < b) begin
          blocked = blocked | !gt[j][b];
        end else if (j > b) begin
          blocked = blocked | gt[b][j];
        end
      end
      best_sel[b] = (basket_votes[b] != '0) && !blocked;
    end
    for (int b = 0; b < NUM_BASKETS; b++) begin
      blocked = 1'b0;
      for (int j = 0; j < NUM_BASKETS; j++) begin
        if (j < b) begin
          blocked = blocked | (qual[j] & !gt[j][b]);
        end else if (j > b) begin
          blocked = blocked | (qual[j] & gt[b][j]);
        end
      end
      second_sel[b] = qual[b] && (basket_votes[b] != '0) && !blocked;
    end
    best_p   = '0;
    best_c   = '0;
    second_p = '0;
    second_c = '0;
    for (int b = 0; b < NUM_BASKETS; b++) begin
      best_p   = best_p   | (basket_start[b] & {POS_W{best_sel[b]}});
      best_c   = best_c   | (basket_votes[b] & {COUNT_W{best_sel[b]}});
      second_p = second_p | (basket_start[b] & {POS_W{second_sel[b]}});
      second_c = second_c | (basket_votes[b] & {COUNT_W{second_sel[b]}});
    end
    report.inserted     = 1'b0;
    report.best_pos     = best_p;
    report.best_count   = best_c;
    report.best_found   = best_c >= hit_threshold;
    report.second_pos   = second_p;
    report.second_count = second_c;
    report.second_found = second_c >= hit_threshold;
  end

endmodule

`default_nettype wire

@@ sv/spvt_outbuf.sv @@
// Result register with one skid entry for the seed position vote table.
// Lets a new beat be taken while a finished result waits. Depends on spvt_pkg.
`default_nettype none

module spvt_outbuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire spvt_pkg::result_t push_data,
  output logic                   full,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output spvt_pkg::result_t      result
);
  import spvt_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (push) begin
      if (!result_valid || pop) begin
        result_valid <= 1'b1;
        result       <= push_data;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end else if (pop) begin
      if (skid_valid) begin
        result     <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/seed_position_vote_table_core.sv @@
// Top level of the seed position vote table: threshold register, basket table,
// winner selection and result buffer. Depends on spvt_pkg, spvt_table,
// spvt_rank and spvt_outbuf.
//
//   channel  | signals                              | beat
//   item     | item_valid, item_stall, item         | vote or finish request
//   result   | result_valid, result_stall, result   | one result per item
//   cfg      | cfg_valid, cfg_ready, cfg_data       | hit threshold write
//
// One item is taken per cycle while item_stall is low; its result goes to
// the result register, or to the skid entry while the output stalls. Vote
// placement and winner selection are combinational logic between the basket
// registers and the result register. Reset clears the baskets and sets the
// threshold to four. The item channel stalls while two results wait.
`default_nettype none

module seed_position_vote_table_core #(
  parameter int NUM_BASKETS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire spvt_pkg::vote_in_t item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output spvt_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);
  import spvt_pkg::*;

  logic [COUNT_W-1:0] hit_threshold;
  logic               take;
  logic               inserted;
  logic [POS_W-1:0]   basket_start [NUM_BASKETS];
  logic [COUNT_W-1:0] basket_votes [NUM_BASKETS];
  result_t            report;
  result_t            beat_result;

  assign cfg_ready = 1'b1;
  assign take      = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hit_threshold <= cfg_data;
    end
  end

  spvt_table #(.NUM_BASKETS(NUM_BASKETS)) u_table (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (item),
    .basket_start (basket_start),
    .basket_votes (basket_votes),
    .inserted     (inserted)
  );

  spvt_rank #(.NUM_BASKETS(NUM_BASKETS)) u_rank (
    .basket_start  (basket_start),
    .basket_votes  (basket_votes),
    .hit_threshold (hit_threshold),
    .report        (report)
  );

  always_comb begin
    if (item.operation == OP_FINISH) begin
      beat_result = report;
    end else begin
      beat_result          = '0;
      beat_result.inserted = inserted;
    end
  end

  spvt_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .push         (take),
    .push_data    (beat_result),
    .full         (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
